FILE: rtl/core/i2c_target_transfer_engine_top_macros.svh
// ============================================================================
// I2C target transfer engine assertion macros
// Shared property wrappers for the transfer engine checks.
// ============================================================================
`ifndef I2C_TARGET_TRANSFER_ENGINE_TOP_MACROS_SVH
`define I2C_TARGET_TRANSFER_ENGINE_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define I2CTE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("i2cte check failed");

// next-cycle implication, disabled while reset is asserted
`define I2CTE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("i2cte check failed");

`endif

FILE: rtl/core/i2cte_pkg.sv
// ============================================================================
// i2cte_pkg
// Types and constants shared by the I2C target transfer engine files.
// ============================================================================
`default_nettype none

package i2cte_pkg;

    // fixed field widths
    localparam int IDX_W  = 6;
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 7;

    // byte sent once the packet runs out
    localparam logic [BYTE_W-1:0] TX_FILLER = 8'hFF;

    // request commands
    typedef enum logic [1:0] {
        CMD_BUS_EVENT   = 2'd0,
        CMD_WR_PACKET   = 2'd1,
        CMD_RD_RECEIVED = 2'd2,
        CMD_SET_LENGTH  = 2'd3
    } t_cmd;

    // transfer phase
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_SEND = 2'd2
    } t_phase;

    // request payload
    typedef struct packed {
        t_cmd              command;
        logic              addr_match;
        logic              master_reads;
        logic              stop_seen;
        logic              rx_ready;
        logic              tx_ready;
        logic              nack_seen;
        logic [BYTE_W-1:0] rx_byte;
        logic [IDX_W-1:0]  buffer_index;
        logic [BYTE_W-1:0] buffer_byte;
        logic [LEN_W-1:0]  packet_length;
    } t_req;

    // response payload
    typedef struct packed {
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              transmit_begin;
        logic              transmit_complete;
        logic              receive_complete;
        logic [LEN_W-1:0]  receive_length;
        logic [BYTE_W-1:0] read_data;
        t_phase            bus_state;
    } t_rsp;

    // control carried alongside the memory read stage
    typedef struct packed {
        logic             valid;
        logic             tx_valid;
        logic             tx_from_mem;
        logic             tbeg;
        logic             tcomp;
        logic             rcomp;
        logic             rd_from_mem;
        logic [LEN_W-1:0] rlen;
        t_phase           phase;
    } t_ctl;

endpackage

`default_nettype wire

FILE: rtl/core/i2cte_req_if.sv
// ============================================================================
// i2cte_req_if
// Request channel of the transfer engine: valid, ready and payload.
// ============================================================================
`default_nettype none

interface i2cte_req_if;
    logic             valid;
    logic             ready;
    i2cte_pkg::t_req  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/i2cte_rsp_if.sv
// ============================================================================
// i2cte_rsp_if
// Response channel of the transfer engine: valid, ready and payload.
// ============================================================================
`default_nettype none

interface i2cte_rsp_if;
    logic             valid;
    logic             ready;
    i2cte_pkg::t_rsp  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/i2c_target_transfer_engine_top.sv
// Pipeline: a request passes the registered buffer memory read stage and then the
// output register before its response is valid; each holds while responses stall.
// Throughput: one request per cycle while responses are taken; receive and packet
// memories each take one write and one read per cycle, so no request waits on another.
// Reset: synchronous, active low; clears phase, counts, bank selects and stage valids.
// The buffer memories are not cleared and need no clearing pass.
// ============================================================================
// i2c_target_transfer_engine_top
// I2C target transfer engine: tracks idle/receive/send phase, collects
// received bytes, publishes them on stop and serves the transmit packet.
// ============================================================================
`default_nettype none
`include "i2c_target_transfer_engine_top_macros.svh"

module i2c_target_transfer_engine_top #(
    parameter int BUFFER_DEPTH = 64
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    i2cte_req_if.sink    i_req,
    i2cte_rsp_if.source  o_rsp
);

    localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int CNT_W  = $clog2(BUFFER_DEPTH + 1);
    localparam int BANK_W = ADDR_W + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(BUFFER_DEPTH);
    localparam logic [31:0]      DEPTH32   = 32'(BUFFER_DEPTH);

    // phase and counters
    i2cte_pkg::t_phase  r_phase, n_phase;
    logic [CNT_W-1:0]   r_coll_cnt, n_coll_cnt;
    logic [CNT_W-1:0]   r_pub_cnt, n_pub_cnt;
    logic [CNT_W-1:0]   r_pkt_cnt, n_pkt_cnt;
    logic [CNT_W-1:0]   r_send_idx, n_send_idx;
    // per entry: which bank of the receive memory holds the published byte
    logic [BUFFER_DEPTH-1:0] r_pub_sel, n_pub_sel;

    // receive memory: two banks, collect side and published side per entry
    logic [i2cte_pkg::BYTE_W-1:0] r_rx_mem [0:(2**BANK_W)-1];
    logic [i2cte_pkg::BYTE_W-1:0] r_pub_q;
    logic                         coll_we;
    logic [BANK_W-1:0]            coll_waddr;
    logic                         pub_re;
    logic [BANK_W-1:0]            pub_raddr;

    // packet memory
    logic [i2cte_pkg::BYTE_W-1:0] r_pkt_mem [0:BUFFER_DEPTH-1];
    logic [i2cte_pkg::BYTE_W-1:0] r_pkt_q;
    logic                         pkt_we;
    logic [ADDR_W-1:0]            pkt_waddr;
    logic                         pkt_re;
    logic [ADDR_W-1:0]            pkt_raddr;

    // pipeline
    i2cte_pkg::t_ctl  ctl;
    i2cte_pkg::t_ctl  r_s1;
    i2cte_pkg::t_rsp  r_out;
    logic             r_out_valid;
    logic             s1_adv;
    logic             s1_load;
    logic             accept;

    // working values for a bus event
    i2cte_pkg::t_phase ph;
    logic [CNT_W-1:0]  cc;
    logic [CNT_W-1:0]  si;
    logic [ADDR_W-1:0] cc_a;
    logic [31:0]       idx_ext;
    logic [ADDR_W-1:0] idx_a;
    logic [31:0]       plen_ext;
    logic [31:0]       pub_ext;

    // check terms
    logic              chk_bus_ev;
    logic              chk_enter_send;
    logic              chk_coll;

    // handshake
    assign s1_adv      = !r_out_valid || o_rsp.ready;
    assign s1_load     = !r_s1.valid || s1_adv;
    assign i_req.ready = s1_load;
    assign accept      = i_req.valid && s1_load;

    assign idx_ext  = 32'(i_req.data.buffer_index);
    assign idx_a    = idx_ext[ADDR_W-1:0];
    assign plen_ext = 32'(i_req.data.packet_length);

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= i2cte_pkg::PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    // next state, memory requests and stage control
    always_comb begin
        n_phase    = r_phase;
        n_coll_cnt = r_coll_cnt;
        n_pub_cnt  = r_pub_cnt;
        n_pkt_cnt  = r_pkt_cnt;
        n_send_idx = r_send_idx;
        n_pub_sel  = r_pub_sel;
        ctl        = '0;
        ctl.valid  = accept;
        coll_we    = 1'b0;
        coll_waddr = '0;
        pub_re     = 1'b0;
        pub_raddr  = '0;
        pkt_we     = 1'b0;
        pkt_waddr  = '0;
        pkt_re     = 1'b0;
        pkt_raddr  = '0;
        ph         = r_phase;
        cc         = r_coll_cnt;
        si         = r_send_idx;
        cc_a       = '0;
        if (accept) begin
            case (i_req.data.command)
                i2cte_pkg::CMD_BUS_EVENT: begin
                    // address match from idle
                    if (r_phase == i2cte_pkg::PH_IDLE && i_req.data.addr_match) begin
                        cc = '0;
                        if (i_req.data.master_reads) begin
                            ph       = i2cte_pkg::PH_SEND;
                            ctl.tbeg = 1'b1;
                            si       = '0;
                        end else begin
                            ph = i2cte_pkg::PH_RECV;
                        end
                    end
                    // stop: return to idle; in receive, publish by flipping bank selects of collected entries
                    if (ph != i2cte_pkg::PH_IDLE && i_req.data.stop_seen) begin
                        if (ph == i2cte_pkg::PH_RECV) begin
                            for (int i = 0; i < BUFFER_DEPTH; i++) begin
                                n_pub_sel[i] = r_pub_sel[i] ^ (CNT_W'(i) < cc);
                            end
                            n_pub_cnt = cc;
                            ctl.rcomp = 1'b1;
                        end else begin
                            ctl.tcomp = 1'b1;
                        end
                        ph = i2cte_pkg::PH_IDLE;
                    end
                    // collect into the bank not holding the published byte
                    if (ph == i2cte_pkg::PH_RECV && i_req.data.rx_ready && cc < DEPTH_CNT) begin
                        cc_a       = cc[ADDR_W-1:0];
                        coll_we    = 1'b1;
                        coll_waddr = {~r_pub_sel[cc_a], cc_a};
                        cc         = cc + 1'b1;
                    end
                    // transmit next packet byte or filler
                    if (ph == i2cte_pkg::PH_SEND && i_req.data.tx_ready
                        && !i_req.data.nack_seen) begin
                        ctl.tx_valid = 1'b1;
                        if (si < r_pkt_cnt && si < DEPTH_CNT) begin
                            pkt_re          = 1'b1;
                            pkt_raddr       = si[ADDR_W-1:0];
                            ctl.tx_from_mem = 1'b1;
                            si              = si + 1'b1;
                        end
                    end
                    n_phase    = ph;
                    n_coll_cnt = cc;
                    n_send_idx = si;
                end
                i2cte_pkg::CMD_WR_PACKET: begin
                    if (idx_ext < DEPTH32) begin
                        pkt_we    = 1'b1;
                        pkt_waddr = idx_a;
                    end
                end
                i2cte_pkg::CMD_RD_RECEIVED: begin
                    if (idx_ext < DEPTH32) begin
                        pub_re          = 1'b1;
                        pub_raddr       = {r_pub_sel[idx_a], idx_a};
                        ctl.rd_from_mem = 1'b1;
                    end
                end
                i2cte_pkg::CMD_SET_LENGTH: begin
                    n_pkt_cnt = (plen_ext > DEPTH32) ? DEPTH_CNT : plen_ext[CNT_W-1:0];
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        pub_ext   = 32'(n_pub_cnt);
        ctl.rlen  = pub_ext[i2cte_pkg::LEN_W-1:0];
        ctl.phase = n_phase;
    end

    // counters and bank selects
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coll_cnt <= '0;
            r_pub_cnt  <= '0;
            r_pkt_cnt  <= '0;
            r_send_idx <= '0;
            r_pub_sel  <= '0;
        end else begin
            r_coll_cnt <= n_coll_cnt;
            r_pub_cnt  <= n_pub_cnt;
            r_pkt_cnt  <= n_pkt_cnt;
            r_send_idx <= n_send_idx;
            r_pub_sel  <= n_pub_sel;
        end
    end

    // receive memory, registered read
    always_ff @(posedge i_clk) begin
        if (coll_we) begin
            r_rx_mem[coll_waddr] <= i_req.data.rx_byte;
        end
        if (pub_re) begin
            r_pub_q <= r_rx_mem[pub_raddr];
        end
    end

    // packet memory, registered read
    always_ff @(posedge i_clk) begin
        if (pkt_we) begin
            r_pkt_mem[pkt_waddr] <= i_req.data.buffer_byte;
        end
        if (pkt_re) begin
            r_pkt_q <= r_pkt_mem[pkt_raddr];
        end
    end

    // read stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1 <= '0;
        end else if (s1_load) begin
            r_s1 <= ctl;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= r_s1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1.valid) begin
            r_out.tx_valid          <= r_s1.tx_valid;
            r_out.tx_byte           <= !r_s1.tx_valid ? '0
                                     : (r_s1.tx_from_mem ? r_pkt_q : i2cte_pkg::TX_FILLER);
            r_out.transmit_begin    <= r_s1.tbeg;
            r_out.transmit_complete <= r_s1.tcomp;
            r_out.receive_complete  <= r_s1.rcomp;
            r_out.receive_length    <= r_s1.rlen;
            r_out.read_data         <= r_s1.rd_from_mem ? r_pub_q : '0;
            r_out.bus_state         <= r_s1.phase;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // checks
    assign chk_bus_ev     = accept && i_req.data.command == i2cte_pkg::CMD_BUS_EVENT
                            && !i_req.data.stop_seen;
    assign chk_enter_send = chk_bus_ev && r_phase == i2cte_pkg::PH_IDLE
                            && i_req.data.addr_match && i_req.data.master_reads;
    assign chk_coll       = chk_bus_ev && r_phase == i2cte_pkg::PH_RECV
                            && i_req.data.rx_ready && r_coll_cnt < DEPTH_CNT;

    `I2CTE_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1.valid && !s1_adv, $stable(r_s1))
    `I2CTE_ASSERT_NEXT(a_enter_send, i_clk, i_rst_n, chk_enter_send, r_phase == i2cte_pkg::PH_SEND)
    `I2CTE_ASSERT_NEXT(a_collect_step, i_clk, i_rst_n, chk_coll, r_coll_cnt == $past(r_coll_cnt) + 1'b1)
    `I2CTE_ASSERT_NOW(a_collect_bound, i_clk, i_rst_n, r_phase == i2cte_pkg::PH_RECV, r_coll_cnt <= DEPTH_CNT)

endmodule

`default_nettype wire

FILE: test/i2c_target_transfer_engine_top_tb.sv
// ============================================================================
// i2c_target_transfer_engine_top_tb
// Drives bus events and host commands into the transfer engine through the
// request channel, predicts each response with a cycle-free model of the
// engine and checks every response field in order. Both channels idle at
// random; the response side stalls for a long stretch once, and the request
// side drains the engine completely at two points.
// ============================================================================
module i2c_target_transfer_engine_top_tb;

    import i2cte_pkg::*;

    localparam int DEPTH            = 64;
    localparam int SHADOW           = 0;    // model copy used to shape stimulus
    localparam int CHECKER          = 1;    // model copy used to predict responses
    localparam int RANDOM_ITEMS     = 750;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int MID_DRAIN_AT     = 500;
    localparam int TAIL_CYCLES      = 8;
    localparam int WATCHDOG_LIMIT   = 5000;

    logic clk = 1'b0;
    logic rst_n;

    i2cte_req_if req_ch();
    i2cte_rsp_if rsp_ch();

    i2c_target_transfer_engine_top #(
        .BUFFER_DEPTH(DEPTH)
    ) uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // engine state, one copy per user
    t_phase     eng_phase     [2];
    logic [7:0] collect_mem   [2][DEPTH];
    logic [6:0] collect_cnt   [2];
    logic [7:0] publish_mem   [2][DEPTH];
    logic [6:0] publish_cnt   [2];
    int         publish_hwm   [2];
    logic [7:0] packet_mem    [2][DEPTH];
    logic [6:0] packet_cnt    [2];
    logic [6:0] send_ptr      [2];
    bit         packet_loaded [2][DEPTH];

    t_req bus_requests [$];
    t_rsp due_responses [$];
    int   drain_points [$];

    int errors;
    int outstanding;
    int sent_count;
    int send_gap;
    int send_calm;
    int take_gap;
    int take_calm;
    int long_hold_left;
    bit long_hold_done;
    int quiet_cycles;

    function automatic bit chance(input int pct);
        return $urandom_range(99) < pct;
    endfunction

    // mostly short pauses, now and then a long one
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 98) return $urandom_range(12, 4);
        return $urandom_range(80, 20);
    endfunction

    // one request through the engine: updates copy m, returns the response
    function automatic t_rsp next_engine_response(input int m, input t_req r);
        t_rsp o;
        o = '0;
        case (r.command)
            CMD_BUS_EVENT: begin
                // address match from idle opens a transfer
                if (eng_phase[m] == PH_IDLE && r.addr_match) begin
                    collect_cnt[m] = '0;
                    if (r.master_reads) begin
                        eng_phase[m]     = PH_SEND;
                        o.transmit_begin = 1'b1;
                        send_ptr[m]      = '0;
                    end else begin
                        eng_phase[m] = PH_RECV;
                    end
                end
                // stop closes it, publishing what was collected
                if (eng_phase[m] != PH_IDLE && r.stop_seen) begin
                    if (eng_phase[m] == PH_RECV) begin
                        for (int i = 0; i < collect_cnt[m]; i++)
                            publish_mem[m][i] = collect_mem[m][i];
                        publish_cnt[m] = collect_cnt[m];
                        if (collect_cnt[m] > publish_hwm[m])
                            publish_hwm[m] = collect_cnt[m];
                        o.receive_complete = 1'b1;
                    end else begin
                        o.transmit_complete = 1'b1;
                    end
                    eng_phase[m] = PH_IDLE;
                end
                // collect, dropping bytes once the store is full
                if (eng_phase[m] == PH_RECV && r.rx_ready && collect_cnt[m] < DEPTH) begin
                    collect_mem[m][collect_cnt[m][5:0]] = r.rx_byte;
                    collect_cnt[m] = collect_cnt[m] + 1'b1;
                end
                // send packet bytes, filler past the end
                if (eng_phase[m] == PH_SEND && r.tx_ready && !r.nack_seen) begin
                    o.tx_valid = 1'b1;
                    if (send_ptr[m] < packet_cnt[m]) begin
                        o.tx_byte   = packet_mem[m][send_ptr[m][5:0]];
                        send_ptr[m] = send_ptr[m] + 1'b1;
                    end else begin
                        o.tx_byte = TX_FILLER;
                    end
                end
            end
            CMD_WR_PACKET: begin
                packet_mem[m][r.buffer_index]    = r.buffer_byte;
                packet_loaded[m][r.buffer_index] = 1'b1;
            end
            CMD_RD_RECEIVED: begin
                o.read_data = publish_mem[m][r.buffer_index];
            end
            default: begin
                packet_cnt[m] = (r.packet_length > DEPTH) ? 7'(DEPTH) : r.packet_length;
            end
        endcase
        o.receive_length = publish_cnt[m];
        o.bus_state      = eng_phase[m];
        return o;
    endfunction

    function automatic t_req random_request();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return t_req'(raw[$bits(t_req)-1:0]);
    endfunction

    function automatic t_req bus_event(input bit addr, input bit mrd, input bit stop,
                                       input bit rxr, input bit txr, input bit nack,
                                       input logic [7:0] rxb);
        t_req r;
        r              = random_request();
        r.command      = CMD_BUS_EVENT;
        r.addr_match   = addr;
        r.master_reads = mrd;
        r.stop_seen    = stop;
        r.rx_ready     = rxr;
        r.tx_ready     = txr;
        r.nack_seen    = nack;
        r.rx_byte      = rxb;
        return r;
    endfunction

    function automatic t_req host_cmd(input t_cmd c, input int idx, input int val);
        t_req r;
        r         = random_request();
        r.command = c;
        case (c)
            CMD_WR_PACKET: begin
                r.buffer_index = idx[5:0];
                r.buffer_byte  = val[7:0];
            end
            CMD_RD_RECEIVED: r.buffer_index  = idx[5:0];
            default:         r.packet_length = val[6:0];
        endcase
        return r;
    endfunction

    // queue a request, steering clear of reads of never-written entries
    task automatic add_item(input t_req r);
        t_phase     nxt;
        logic [6:0] ptr;
        if (r.command == CMD_RD_RECEIVED) begin
            if (publish_hwm[SHADOW] == 0) return;
            if (r.buffer_index >= publish_hwm[SHADOW])
                r.buffer_index = 6'($urandom_range(publish_hwm[SHADOW] - 1));
        end
        if (r.command == CMD_BUS_EVENT) begin
            nxt = eng_phase[SHADOW];
            ptr = send_ptr[SHADOW];
            if (nxt == PH_IDLE && r.addr_match) begin
                nxt = r.master_reads ? PH_SEND : PH_RECV;
                ptr = '0;
            end
            if (nxt != PH_IDLE && r.stop_seen)
                nxt = PH_IDLE;
            if (nxt == PH_SEND && r.tx_ready && !r.nack_seen && ptr < packet_cnt[SHADOW]
                    && !packet_loaded[SHADOW][ptr[5:0]])
                r.tx_ready = 1'b0;
        end
        void'(next_engine_response(SHADOW, r));
        bus_requests.push_back(r);
    endtask

    // master writes nbytes to the target, then the host reads a few back
    task automatic run_receive(input int nbytes);
        int nreads;
        add_item(bus_event(1'b1, 1'b0, 1'b0, chance(50), 1'b0, 1'b0, 8'($urandom)));
        for (int i = 0; i < nbytes; i++)
            add_item(bus_event(chance(10), chance(50), 1'b0, chance(92), chance(15),
                               chance(15), 8'($urandom)));
        add_item(bus_event(1'b0, 1'b0, 1'b1, chance(30), chance(20), 1'b0, 8'($urandom)));
        nreads = $urandom_range(3);
        for (int i = 0; i < nreads; i++)
            add_item(host_cmd(CMD_RD_RECEIVED, $urandom_range(63), 0));
    endtask

    // host loads a packet of k bytes, master reads it out
    task automatic run_transmit(input int k, input int len);
        int nreads;
        for (int i = 0; i < k; i++)
            add_item(host_cmd(CMD_WR_PACKET, i, $urandom_range(255)));
        add_item(host_cmd(CMD_SET_LENGTH, 0, len));
        add_item(bus_event(1'b1, 1'b1, 1'b0, chance(20), chance(50), chance(15),
                           8'($urandom)));
        nreads = k + $urandom_range(3);
        for (int i = 0; i < nreads; i++)
            add_item(bus_event(chance(10), chance(50), 1'b0, chance(15), chance(88),
                               chance(12), 8'($urandom)));
        add_item(bus_event(1'b0, chance(50), 1'b1, chance(20), chance(30), 1'b0,
                           8'($urandom)));
    endtask

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
        end
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            req_ch.valid <= 1'b0;
            req_ch.data  <= '0;
            sent_count   <= 0;
            send_gap     <= 0;
            send_calm    <= 0;
        end else if (!req_ch.valid || req_ch.ready) begin
            // a drain point is released once every response is in
            if (drain_points.size() != 0 && drain_points[0] == sent_count
                    && !req_ch.valid && outstanding == 0)
                void'(drain_points.pop_front());
            if (send_gap > 0) begin
                req_ch.valid <= 1'b0;
                send_gap     <= send_gap - 1;
            end else if (bus_requests.size() != 0
                    && !(drain_points.size() != 0 && drain_points[0] == sent_count)) begin
                req_ch.valid <= 1'b1;
                req_ch.data  <= bus_requests.pop_front();
                sent_count   <= sent_count + 1;
                if (send_calm > 0) begin
                    send_gap  <= 0;
                    send_calm <= send_calm - 1;
                end else begin
                    send_gap <= pick_pause();
                    if (chance(4)) send_calm <= $urandom_range(100, 30);
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // response ready, with one long hold to back the engine up
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ch.ready   <= 1'b0;
            take_gap       <= 0;
            take_calm      <= 0;
            long_hold_left <= 0;
            long_hold_done <= 1'b0;
        end else if (!long_hold_done && sent_count >= LONG_HOLD_AT) begin
            rsp_ch.ready   <= 1'b0;
            long_hold_left <= LONG_HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end else if (long_hold_left > 0) begin
            rsp_ch.ready   <= 1'b0;
            long_hold_left <= long_hold_left - 1;
        end else if (take_gap > 0) begin
            rsp_ch.ready <= 1'b0;
            take_gap     <= take_gap - 1;
        end else begin
            rsp_ch.ready <= 1'b1;
            if (take_calm > 0) begin
                take_calm <= take_calm - 1;
            end else begin
                take_gap <= pick_pause();
                if (chance(4)) take_calm <= $urandom_range(100, 30);
            end
        end
    end

    // monitor: predict on each accepted request, check each accepted response
    always @(posedge clk) begin : response_check
        t_rsp want;
        t_rsp got;
        bit   took_req;
        bit   took_rsp;
        if (!rst_n) begin
            outstanding <= 0;
        end else begin
            took_req = req_ch.valid && req_ch.ready;
            took_rsp = rsp_ch.valid && rsp_ch.ready;
            if (took_rsp) begin
                got = rsp_ch.data;
                if (due_responses.size() == 0) begin
                    errors++;
                    $display("%0t: response with none expected, expected nothing, got %h",
                             $time, got);
                end else begin
                    want = due_responses.pop_front();
                    check_field("tx_valid", want.tx_valid, got.tx_valid);
                    check_field("tx_byte", want.tx_byte, got.tx_byte);
                    check_field("transmit_begin", want.transmit_begin, got.transmit_begin);
                    check_field("transmit_complete", want.transmit_complete,
                                got.transmit_complete);
                    check_field("receive_complete", want.receive_complete,
                                got.receive_complete);
                    check_field("receive_length", want.receive_length, got.receive_length);
                    check_field("read_data", want.read_data, got.read_data);
                    check_field("bus_state", want.bus_state, got.bus_state);
                end
            end
            if (took_req)
                due_responses.push_back(next_engine_response(CHECKER, req_ch.data));
            outstanding <= outstanding + int'(took_req) - int'(took_rsp);
        end
    end

    // watchdog on cycles with no handshake at all
    always @(posedge clk) begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int total;
        int target;
        int roll;
        int k;
        int n;
        bit mid_drain_set;
        t_req r;

        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        rsp_ch.ready  = 1'b0;
        errors        = 0;
        quiet_cycles  = 0;
        mid_drain_set = 1'b0;

        for (int m = 0; m < 2; m++) begin
            eng_phase[m]   = PH_IDLE;
            collect_cnt[m] = '0;
            publish_cnt[m] = '0;
            publish_hwm[m] = 0;
            packet_cnt[m]  = '0;
            send_ptr[m]    = '0;
            for (int i = 0; i < DEPTH; i++) begin
                collect_mem[m][i]   = '0;
                publish_mem[m][i]   = '0;
                packet_mem[m][i]    = '0;
                packet_loaded[m][i] = 1'b0;
            end
        end

        // directed: stray events while idle
        add_item(bus_event(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 8'h5A));
        // short packet, index extremes
        add_item(host_cmd(CMD_WR_PACKET, 0, 8'h00));
        add_item(host_cmd(CMD_WR_PACKET, 1, 8'hFF));
        add_item(host_cmd(CMD_WR_PACKET, 63, 8'hA5));
        add_item(host_cmd(CMD_WR_PACKET, 2, 8'h3C));
        add_item(host_cmd(CMD_SET_LENGTH, 0, 3));
        // read transfer: begin with a byte, NACK, address while busy, filler, stop
        add_item(bus_event(1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        add_item(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 8'h00));
        add_item(bus_event(1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 8'h11));
        add_item(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        add_item(bus_event(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
        add_item(bus_event(1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        // write transfer: byte extremes, tx_ready ignored, byte dropped with stop
        add_item(bus_event(1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'h00));
        add_item(bus_event(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 8'hFF));
        add_item(bus_event(1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 8'h81));
        add_item(bus_event(1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 8'h77));
        add_item(host_cmd(CMD_RD_RECEIVED, 0, 0));
        add_item(host_cmd(CMD_RD_RECEIVED, 2, 0));
        // empty write transfer, then a read past the published count
        add_item(bus_event(1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
        add_item(host_cmd(CMD_RD_RECEIVED, 1, 0));
        // read transfer opened and closed at once
        add_item(bus_event(1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00));
        // length above the buffer size saturates
        add_item(host_cmd(CMD_SET_LENGTH, 0, 127));
        add_item(host_cmd(CMD_SET_LENGTH, 0, 0));
        drain_points.push_back(bus_requests.size());

        // random: full packet beyond its length, then an overflowing receive
        target = bus_requests.size() + RANDOM_ITEMS;
        run_transmit(DEPTH, $urandom_range(127, DEPTH));
        run_receive($urandom_range(70, DEPTH + 1));
        while (bus_requests.size() < target) begin
            if (!mid_drain_set && bus_requests.size() >= MID_DRAIN_AT) begin
                drain_points.push_back(bus_requests.size());
                mid_drain_set = 1'b1;
            end
            roll = $urandom_range(99);
            if (roll < 35) begin
                run_receive(chance(10) ? $urandom_range(70, 60) : $urandom_range(8));
            end else if (roll < 70) begin
                k = chance(5) ? DEPTH : $urandom_range(8);
                run_transmit(k, chance(85) ? k : $urandom_range(127));
            end else if (roll < 85) begin
                n = $urandom_range(4, 1);
                for (int i = 0; i < n; i++)
                    add_item(host_cmd(t_cmd'($urandom_range(3, 1)), $urandom_range(63),
                                      $urandom_range(255)));
            end else begin
                n = $urandom_range(5, 1);
                for (int i = 0; i < n; i++) begin
                    r         = random_request();
                    r.command = CMD_BUS_EVENT;
                    add_item(r);
                end
            end
        end
        total = bus_requests.size();

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total || req_ch.valid || outstanding != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (due_responses.size() != 0) begin
            errors += due_responses.size();
            $display("%0t: responses missing, expected %0d more, got none", $time,
                     due_responses.size());
        end
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/i2cte_pkg.sv
rtl/core/i2cte_req_if.sv
rtl/core/i2cte_rsp_if.sv
rtl/core/i2c_target_transfer_engine_top.sv
test/i2c_target_transfer_engine_top_tb.sv
